// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLKED(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Default form: uses clk and arst_n from the enclosing scope.
`define ASSERT_DEF(lbl, prop, msg) \
	`ASSERT_CLKED(lbl, clk, arst_n, prop, msg)

`endif

// ----- rtl/rto_pkg.sv -----
`timescale 1ns / 1ps
package rto_pkg;

	// Output fields are fixed at eight lines regardless of populated channels
	localparam int unsigned NUM_LINES = 8;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned CHCNT_W   = 4;

	// Register reset values
	localparam logic [CHCNT_W-1:0] CHAN_COUNT_RESET = 4'd0;
	localparam logic [CNT_W-1:0]   TIMEOUT_RESET    = 8'd2;

	// Item opcodes
	typedef enum logic {
		OP_TRIGGER = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	// Register select (address bit 2)
	typedef enum logic {
		REG_CHAN_COUNT = 1'b0,
		REG_TIMEOUT    = 1'b1
	} reg_sel_t;

	// Per-beat control broadcast to every channel
	typedef struct packed {
		logic fire;       // item in stage 1 is applied this cycle
		op_t  opcode;
		logic mask_zero;  // trigger with empty mask: release all
		logic clear;      // channel_count write: release all
	} rto_step_t;

endpackage

// ----- rtl/rto_in_if.sv -----
`timescale 1ns / 1ps
interface rto_in_if;
	import rto_pkg::*;

	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] channel_mask;

	modport source (output valid, output opcode, output channel_mask, input ready);
	modport sink   (input valid, input opcode, input channel_mask, output ready);

endinterface

// ----- rtl/rto_out_if.sv -----
`timescale 1ns / 1ps
interface rto_out_if;
	import rto_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] line_levels;
	logic [7:0] active_mask;

	modport source (output valid, output line_levels, output active_mask, input ready);
	modport sink   (input valid, input line_levels, input active_mask, output ready);

endinterface

// ----- rtl/retriggerable_trigger_outputs.sv -----
`timescale 1ns / 1ps
// Bank of NUM_CHANNELS retriggerable active-low one-shots. Each input beat
// (trigger with channel mask, or one timer tick) yields exactly one result beat
// with the line levels and active mask after that beat. A new beat is accepted
// every cycle unless the result side stalls; each beat passes the input register,
// then the result register. Channels update in parallel, one small state machine
// per channel. Registers: channel_count at 0x0 (writing it releases all lines),
// timeout_ticks at 0x4 (reset 2). No start-up sweep.
module retriggerable_trigger_outputs
	import rto_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	rto_in_if.sink      in_ch,
	rto_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers
	logic [CHCNT_W-1:0] chan_count_q;
	logic [CNT_W-1:0]   timeout_q;
	logic               cfg_wr;
	reg_sel_t           reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= CHAN_COUNT_RESET;
			timeout_q    <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CHAN_COUNT: chan_count_q <= pwdata[CHCNT_W-1:0];
				REG_TIMEOUT:    timeout_q    <= pwdata[CNT_W-1:0];
				default:        timeout_q    <= timeout_q;
			endcase
		end
	end

	// Read data
	always_comb begin
		case (reg_sel)
			REG_CHAN_COUNT: prdata = {{(32-CHCNT_W){1'b0}}, chan_count_q};
			REG_TIMEOUT:    prdata = {{(32-CNT_W){1'b0}}, timeout_q};
			default:        prdata = '0;
		endcase
	end

	// Pipeline control
	logic           valid_s1;
	op_t            opcode_s1;
	logic [7:0]     mask_s1;
	logic           out_valid_s2;
	logic [7:0]     active_s2;
	logic           adv;
	logic           in_beat;

	assign adv         = !out_valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;
	assign in_beat     = in_ch.valid && in_ch.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			opcode_s1 <= op_t'(in_ch.opcode);
			mask_s1   <= in_ch.channel_mask;
		end
	end

	// Channel bank
	rto_step_t               step;
	logic [NUM_CHANNELS-1:0] act_nxt;
	logic [NUM_LINES-1:0]    act_all;

	assign step.fire      = valid_s1 && adv;
	assign step.opcode    = opcode_s1;
	assign step.mask_zero = (mask_s1 == '0);
	assign step.clear     = cfg_wr && (reg_sel == REG_CHAN_COUNT);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		rto_chan u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (step),
			.enable     (CHCNT_W'(i) < chan_count_q),
			.mask_bit   (mask_s1[i]),
			.timeout    (timeout_q),
			.active_nxt (act_nxt[i])
		);
	end

	// Absent channels read inactive
	always_comb begin
		act_all                 = '0;
		act_all[NUM_CHANNELS-1:0] = act_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			active_s2 <= act_all;
		end
	end

	assign out_ch.valid       = out_valid_s2;
	assign out_ch.active_mask = active_s2;
	assign out_ch.line_levels = ~active_s2;

endmodule

// ----- rtl/rto_chan.sv -----
`timescale 1ns / 1ps
module rto_chan
	import rto_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rto_step_t        step,
	input  logic             enable,
	input  logic             mask_bit,
	input  logic [CNT_W-1:0] timeout,
	output logic             active_nxt
);

	logic             active_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             expired;

	assign expired = (cnt_q >= timeout);

	// One-shot next state
	always_comb begin
		active_nxt = active_q;
		cnt_nxt    = cnt_q;
		if (step.clear) begin
			active_nxt = 1'b0;
		end else if (step.fire && enable) begin
			case (step.opcode)
				OP_TRIGGER: begin
					if (step.mask_zero) begin
						active_nxt = 1'b0;
					end else if (mask_bit) begin
						active_nxt = 1'b1;
						cnt_nxt    = '0;
					end
				end
				OP_TICK: begin
					if (active_q) begin
						if (expired) begin
							active_nxt = 1'b0;
							cnt_nxt    = '0;
						end else begin
							cnt_nxt = cnt_q + 1'b1;
						end
					end
				end
				default: begin
					active_nxt = active_q;
				end
			endcase
		end
	end

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			active_q <= active_nxt;
			cnt_q    <= cnt_nxt;
		end
	end

endmodule

// ----- rtl/rto_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rto_chk #(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  line_levels,
	input logic [7:0]  active_mask,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	logic [7:0] absent_mask;
	logic       tmo_wr;
	logic       tmo_rd;

	assign absent_mask = ~(8'hFF >> (8 - NUM_CHANNELS));
	assign tmo_wr      = psel && penable && pwrite && paddr[2];
	assign tmo_rd      = psel && !pwrite && paddr[2];

	// Every line is low exactly when its channel is active
	`ASSERT_DEF(a_levels_match, out_valid |-> (line_levels == ~active_mask), "levels/active mismatch")

	// Unpopulated channels never go active
	`ASSERT_DEF(a_absent_idle, out_valid |-> ((active_mask & absent_mask) == 8'h00), "absent channel active")

	// Stalled result beat holds
	`ASSERT_DEF(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(active_mask)), "result changed while stalled")

	// Timeout reads back what was just written
	`ASSERT_DEF(a_tmo_readback, tmo_wr ##1 tmo_rd |-> (prdata[7:0] == $past(pwdata[7:0])), "timeout readback")

endmodule

bind retriggerable_trigger_outputs rto_chk #(.NUM_CHANNELS(NUM_CHANNELS)) u_rto_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.line_levels (out_ch.line_levels),
	.active_mask (out_ch.active_mask),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);

// ----- test/retriggerable_trigger_outputs_test.sv -----
`timescale 1ns / 1ps
module retriggerable_trigger_outputs_test;
	import rto_pkg::*;

	localparam int unsigned NCH        = 8;
	localparam int unsigned LATENCY    = 2;
	localparam int unsigned QUIET_LIMIT = 500;

	typedef struct packed {
		op_t        opcode;
		logic [7:0] channel_mask;
	} beat_t;

	typedef struct packed {
		logic [7:0] line_levels;
		logic [7:0] active_mask;
	} levels_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rto_in_if  in_bus ();
	rto_out_if out_bus ();

	retriggerable_trigger_outputs #(
		.NUM_CHANNELS(NCH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_bus),
		.out_ch  (out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the bank: configuration, active flags, per-channel tick counters
	logic [3:0] shadow_chan_count;
	logic [7:0] shadow_timeout;
	logic [7:0] shadow_active;
	logic [7:0] shadow_ticks [NCH];

	beat_t   beats_pending [$];
	levels_t levels_due [$];

	int unsigned n_beats;
	int unsigned n_results;
	int unsigned n_writes;
	int unsigned n_errors;
	int unsigned quiet_cycles;
	int unsigned send_gap;
	int unsigned recv_stall;
	bit          calm;
	bit          in_took;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one beat to the shadow bank and return the levels it leaves behind
	function automatic levels_t bank_step(beat_t b);
		int unsigned n;
		logic [7:0]  c;
		levels_t     r;
		n = (shadow_chan_count > NCH) ? NCH : shadow_chan_count;
		if (b.opcode == OP_TRIGGER) begin
			for (int i = 0; i < n; i++) begin
				if (b.channel_mask == 8'h00) begin
					shadow_active[i] = 1'b0;
				end else if (b.channel_mask[i]) begin
					shadow_active[i] = 1'b1;
					shadow_ticks[i] = 8'h00;
				end
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				if (shadow_active[i]) begin
					c = shadow_ticks[i];
					shadow_ticks[i] = c + 8'd1;
					if (c >= shadow_timeout) begin
						shadow_ticks[i] = 8'h00;
						shadow_active[i] = 1'b0;
					end
				end
			end
		end
		r.line_levels = ~shadow_active;
		r.active_mask = shadow_active;
		return r;
	endfunction

	// Register write with read-back, both through the APB port
	task automatic reg_write(reg_sel_t sel, logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_CHAN_COUNT) begin
			shadow_chan_count = value[3:0];
			shadow_active = 8'h00;
			want = {28'd0, value[3:0]};
		end else begin
			shadow_timeout = value[7:0];
			want = {24'd0, value[7:0]};
		end
		n_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_CHAN_COUNT ? (prdata[3:0] !== want[3:0]) : (prdata[7:0] !== want[7:0]))
		begin
			$display("%0t: read-back of %s expected %0h actual %0h",
				$time, sel.name(), want, prdata);
			n_errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_beat(op_t op, logic [7:0] mask);
		beat_t b;
		b.opcode = op;
		b.channel_mask = mask;
		beats_pending.push_back(b);
	endtask

	// Block is idle once every beat is in and every result is out
	task automatic drain();
		while (beats_pending.size() != 0 || levels_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Mixed traffic: mostly ticks so that timeouts fire, triggers with varied masks
	task automatic push_mix(int unsigned count);
		int unsigned r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_beat(OP_TICK, 8'($urandom));
			end else if (r < 76) begin
				push_beat(OP_TRIGGER, 8'h00);
			end else if (r < 82) begin
				push_beat(OP_TRIGGER, 8'hFF);
			end else begin
				push_beat(OP_TRIGGER, 8'($urandom));
			end
		end
	endtask

	// Input side: record accepted beats and predict their results
	always @(posedge clk) begin
		if (arst_n && in_bus.valid && in_bus.ready) begin
			beat_t b;
			b.opcode = op_t'(in_bus.opcode);
			b.channel_mask = in_bus.channel_mask;
			levels_due.push_back(bank_step(b));
			void'(beats_pending.pop_front());
			n_beats++;
			in_took = 1'b1;
		end
	end

	// Driver: present the next pending beat, with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
		end else if (in_bus.valid && !in_took) begin
			// hold the beat until it is taken
		end else if (send_gap > 0 || beats_pending.size() == 0) begin
			if (send_gap > 0) send_gap--;
			in_bus.valid        <= 1'b0;
			in_bus.opcode       <= 1'($urandom_range(0, 1));
			in_bus.channel_mask <= 8'($urandom);
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			send_gap = $urandom_range(1, 17) - 1;
			in_bus.valid <= 1'b0;
		end else begin
			in_bus.valid        <= 1'b1;
			in_bus.opcode       <= beats_pending[0].opcode;
			in_bus.channel_mask <= beats_pending[0].channel_mask;
		end
		in_took = 1'b0;
	end

	// Result side back-pressure in random bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_bus.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			recv_stall = $urandom_range(1, 17) - 1;
			out_bus.ready <= 1'b0;
		end else begin
			out_bus.ready <= 1'b1;
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready) begin
			levels_t want;
			n_results++;
			if (levels_due.size() == 0) begin
				$display("%0t: result with nothing expected, line_levels %02h active_mask %02h",
					$time, out_bus.line_levels, out_bus.active_mask);
				n_errors++;
			end else begin
				want = levels_due.pop_front();
				if (out_bus.line_levels !== want.line_levels) begin
					$display("%0t: line_levels expected %02h actual %02h",
						$time, want.line_levels, out_bus.line_levels);
					n_errors++;
				end
				if (out_bus.active_mask !== want.active_mask) begin
					$display("%0t: active_mask expected %02h actual %02h",
						$time, want.active_mask, out_bus.active_mask);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
			(psel && penable) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		int unsigned cc;
		int unsigned to;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.opcode = 1'b0;
		in_bus.channel_mask = 8'h00;
		out_bus.ready = 1'b0;
		shadow_chan_count = CHAN_COUNT_RESET;
		shadow_timeout = TIMEOUT_RESET;
		shadow_active = 8'h00;
		for (int i = 0; i < NCH; i++) shadow_ticks[i] = 8'h00;
		n_beats = 0;
		n_results = 0;
		n_writes = 0;
		n_errors = 0;
		quiet_cycles = 0;
		send_gap = 0;
		recv_stall = 0;
		calm = 1'b0;
		in_took = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: no channel enabled
		push_beat(OP_TRIGGER, 8'hFF);
		push_beat(OP_TICK, 8'h00);
		drain();

		// All eight channels, default timeout
		reg_write(REG_CHAN_COUNT, 32'd8);
		reg_write(REG_TIMEOUT, 32'd2);
		push_beat(OP_TRIGGER, 8'h01);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TICK, 8'hFF);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TRIGGER, 8'h80);
		push_beat(OP_TRIGGER, 8'hFF);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TRIGGER, 8'hAA);  // retrigger half the active ones
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TRIGGER, 8'h00);  // release everything
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TRIGGER, 8'h55);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TICK, 8'h00);
		drain();

		// Three channels, zero timeout; masks on disabled channels are dropped
		reg_write(REG_CHAN_COUNT, 32'd3);
		reg_write(REG_TIMEOUT, 32'd0);
		push_beat(OP_TRIGGER, 8'hFF);
		push_beat(OP_TICK, 8'h00);
		push_beat(OP_TRIGGER, 8'hF8);
		push_beat(OP_TICK, 8'h00);
		drain();

		// Count above the channel number enables all of them
		reg_write(REG_CHAN_COUNT, 32'd15);
		push_beat(OP_TRIGGER, 8'hFF);
		push_beat(OP_TRIGGER, 8'h00);
		drain();

		// Largest timeout: counter climbs to 255 and is released there
		reg_write(REG_CHAN_COUNT, 32'd8);
		reg_write(REG_TIMEOUT, 32'd255);
		push_beat(OP_TRIGGER, 8'hFF);
		for (int i = 0; i < 257; i++) push_beat(OP_TICK, 8'($urandom));
		drain();

		// Random phases over a spread of settings
		for (int k = 0; k < 8; k++) begin
			case (k)
				0: begin cc = 8; to = 0; end
				1: begin cc = 15; to = $urandom_range(0, 6); end
				2: begin cc = 0; to = $urandom_range(0, 6); end
				3: begin cc = $urandom_range(1, 15); to = 255; end
				default: begin cc = $urandom_range(1, 15); to = $urandom_range(0, 6); end
			endcase
			if (k == 7) calm = 1'b1;
			reg_write(REG_CHAN_COUNT, 32'(cc));
			reg_write(REG_TIMEOUT, 32'(to));
			push_mix(15);
			drain();
		end

		$display("Sent %0d beats and checked %0d results across %0d register writes.",
			n_beats, n_results, n_writes);
		$display("Covered channel counts 0 to 15 and timeouts from 0 to 255 with back-pressure.");
		if (n_errors == 0 && levels_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rto_pkg.sv
rtl/rto_in_if.sv
rtl/rto_out_if.sv
rtl/rto_chan.sv
rtl/retriggerable_trigger_outputs.sv
rtl/rto_chk.sv
test/retriggerable_trigger_outputs_test.sv
